// ----- sv/cscan_disk_scheduler_defines.svh -----
// Assertion macros for the C-SCAN disk scheduler.
// Taken in by every file that carries concurrent checks; no other dependencies.
`ifndef CSCAN_DISK_SCHEDULER_DEFINES_SVH
`define CSCAN_DISK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define CSCAN_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define CSCAN_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/cscan_pkg.sv -----
// Shared constants and types for the C-SCAN disk scheduler.
// No dependencies; imported by cscan_avg_div and cscan_disk_scheduler.
package cscan_pkg;

  localparam int DT_W      = 17;  // disk_tracks register
  localparam int SH_W      = 16;  // start_head register
  localparam int CFG_D_W   = 17;
  localparam int CFG_IDX_W = 2;
  localparam int TOTAL_W   = 22;
  localparam int AVG_W     = 24;
  localparam int DVD_W     = TOTAL_W + 8;  // total in Q8
  localparam int DIV_CNT_W = $clog2(DVD_W);

  localparam logic [CFG_IDX_W-1:0] CFG_DISK_TRACKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD  = 2'd1;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [AVG_W-1:0]   AVG_MAX   = {AVG_W{1'b1}};

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
  } div_res_t;

endpackage

// ----- sv/cscan_avg_div.sv -----
// Restoring serial divider for the batch average, one quotient bit a cycle.
// Depends on cscan_pkg.
module cscan_avg_div import cscan_pkg::*; #(
  parameter int DVS_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output div_res_t         res
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0]     rem_r;
  logic [DVS_W-1:0]     dvs_r;
  logic [DVD_W-1:0]     q_r;
  logic [DVS_W:0]       rem_sh;
  logic                 fits;

  assign rem_sh = {rem_r, q_r[DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      // shift in next dividend bit, subtract where it fits
      q_r   <= {q_r[DVD_W-2:0], fits};
      rem_r <= fits ? DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVS_W-1:0];
    end
  end

  assign res.done = done_r;
  assign res.quot = q_r;

endmodule

// ----- sv/cscan_disk_scheduler.sv -----
// C-SCAN disk scheduler: top level. Depends on cscan_pkg, cscan_avg_div and the defines header.
// Load: one request per cycle while in_stall is low (it is high outside idle). After the last request
// the head, 0 and end entries are appended; then each row costs one pass over the n = requests + 3
// stored entries through the single memory read port; the last row also waits for the divider.
// A batch of r requests gives r + 4 rows. Synchronous active-low reset clears control state
// and sets disk_tracks to 200 and start_head to 0; the store itself is not cleared.
`include "cscan_disk_scheduler_defines.svh"
module cscan_disk_scheduler import cscan_pkg::*; #(
  parameter int MAX_REQUESTS = 32,
  parameter int TRACK_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TRACK_BITS-1:0] in_track,
  input  logic                  in_last_request,
  // schedule rows
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TRACK_BITS-1:0] out_from_track,
  output logic [TRACK_BITS-1:0] out_to_track,
  output logic [TRACK_BITS-1:0] out_seek_distance,
  output logic [TOTAL_W-1:0]    out_total_moved,
  output logic [AVG_W-1:0]      out_average_q8,
  output logic                  out_last_row,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_D_W-1:0]    cfg_data
);

  localparam int DEPTH = MAX_REQUESTS + 3;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);
  localparam int CW    = $clog2(MAX_REQUESTS + 1);
  localparam int EXW   = 34;
  localparam int SUMX  = (TRACK_BITS > TOTAL_W ? TRACK_BITS : TOTAL_W) + 1;
  localparam logic [EXW-1:0] TMASK = (EXW'(1) << TRACK_BITS) - EXW'(1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_APPEND = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_ROW    = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;

  localparam logic [1:0] APP_HEAD = 2'd0;
  localparam logic [1:0] APP_ZERO = 2'd1;
  localparam logic [1:0] APP_END  = 2'd2;

  // Configuration registers
  logic [DT_W-1:0] disk_tracks_r;
  logic [SH_W-1:0] start_head_r;

  // Sequencer state
  logic [2:0]            state_r;
  logic [CW-1:0]         cnt_r;       // requests stored in the open batch
  logic [CW-1:0]         real_r;      // requests of the batch being walked
  logic [NW-1:0]         n_r;         // entries in the store incl. head, 0, end
  logic [1:0]            app_r;
  logic [TRACK_BITS-1:0] head_r;
  logic [TRACK_BITS-1:0] endm_r;

  // Scan state: last emitted key, best candidate of the running pass
  logic                  upper_r;     // walking entries at or above the head
  logic                  cur_none_r;
  logic [TRACK_BITS-1:0] cur_val_r;
  logic [AW-1:0]         cur_idx_r;
  logic                  best_found_r;
  logic [TRACK_BITS-1:0] best_val_r;
  logic [AW-1:0]         best_idx_r;
  logic [NW-1:0]         iss_r;
  logic                  rd_vld_r;
  logic [AW-1:0]         rd_idx_r;
  logic [TRACK_BITS-1:0] rd_data_r;
  logic [NW-1:0]         row_cnt_r;

  // Walk state
  logic [TRACK_BITS-1:0] hp_r;
  logic [TOTAL_W-1:0]    sum_r;
  logic                  out_valid_r;

  // Request store
  logic [TRACK_BITS-1:0] mem [DEPTH];
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [TRACK_BITS-1:0] wr_data;
  logic [AW-1:0]         rd_addr;

  logic                  in_acc;
  logic                  cnt_room;
  logic [CW-1:0]         cnt_inc;
  logic [EXW-1:0]        endm_w;
  logic [EXW-1:0]        head_w;
  logic                  seg;
  logic                  gt;
  logic                  take;
  logic                  out_free;
  logic [TRACK_BITS-1:0] to_w;
  logic [TRACK_BITS-1:0] dist_w;
  logic [SUMX-1:0]       sum_ext;
  logic [TOTAL_W-1:0]    sum_nxt;
  logic                  row_last;
  logic                  div_start;
  div_res_t              div_res;

  assign cfg_ready = 1'b1;
  assign in_stall  = state_r != S_IDLE;
  assign in_acc    = in_valid && !in_stall;
  assign cnt_room  = cnt_r < CW'(MAX_REQUESTS);
  assign cnt_inc   = cnt_room ? cnt_r + 1'b1 : cnt_r;

  // End marker: disk_tracks - 1, zero for an empty disk, saturated at the top track
  always_comb begin
    endm_w = (disk_tracks_r == '0) ? '0 : EXW'(disk_tracks_r) - EXW'(1);
    if (endm_w > TMASK) endm_w = TMASK;
    head_w = EXW'(start_head_r) & TMASK;
  end

  // Single write port: requests while loading, then the three extra entries
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AW'(real_r) + AW'(app_r);
    wr_data = head_r;
    if (state_r == S_IDLE) begin
      wr_en   = in_acc && cnt_room;
      wr_addr = AW'(cnt_r);
      wr_data = in_track;
    end else if (state_r == S_APPEND) begin
      wr_en = 1'b1;
      unique case (app_r)
        APP_HEAD: wr_data = head_r;
        APP_ZERO: wr_data = '0;
        default:  wr_data = endm_r;
      endcase
    end
  end

  assign rd_addr = iss_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  // Candidate test: in this half of the sweep, after the last key, below the best so far.
  // Keys order by track, then by store index, so duplicates come out one by one.
  always_comb begin
    seg  = upper_r ? (rd_data_r >= head_r) : (rd_data_r < head_r);
    gt   = cur_none_r || (rd_data_r > cur_val_r) ||
           ((rd_data_r == cur_val_r) && (rd_idx_r > cur_idx_r));
    take = rd_vld_r && seg && gt && (!best_found_r || (rd_data_r < best_val_r));
  end

  // Row arithmetic: no candidate in the upper half means the jump to track 0
  assign out_free = !out_valid_r || !out_stall;
  assign to_w     = best_found_r ? best_val_r : '0;
  assign dist_w   = (hp_r > to_w) ? hp_r - to_w : to_w - hp_r;
  assign sum_ext  = SUMX'(sum_r) + SUMX'(dist_w);
  assign sum_nxt  = (sum_ext > SUMX'(TOTAL_MAX)) ? TOTAL_MAX : sum_ext[TOTAL_W-1:0];
  assign row_last = row_cnt_r == n_r;
  assign div_start = (state_r == S_ROW) && out_free && row_last;

  cscan_avg_div #(
    .DVS_W (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({sum_nxt, 8'd0}),
    .divisor  (real_r),
    .res      (div_res)
  );

  // Configuration: unknown indices fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_tracks_r <= DT_W'(200);
      start_head_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_DISK_TRACKS) disk_tracks_r <= cfg_data[DT_W-1:0];
      else if (cfg_index == CFG_START_HEAD) start_head_r <= cfg_data[SH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      rd_vld_r     <= 1'b0;
      best_found_r <= 1'b0;
      app_r        <= APP_HEAD;
      iss_r        <= '0;
      row_cnt_r    <= '0;
    end else begin
      // drop a taken row; the row state reloads the register itself
      if (out_valid_r && !out_stall && (state_r != S_ROW)) out_valid_r <= 1'b0;
      rd_vld_r <= (state_r == S_SCAN) && (iss_r < n_r);
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            // marked item closes the batch; drop requests beyond capacity
            cnt_r <= in_last_request ? '0 : cnt_inc;
            if (in_last_request) begin
              real_r  <= cnt_inc;
              n_r     <= NW'(cnt_inc) + NW'(3);
              head_r  <= head_w[TRACK_BITS-1:0];
              endm_r  <= endm_w[TRACK_BITS-1:0];
              app_r   <= APP_HEAD;
              state_r <= S_APPEND;
            end
          end
        end
        S_APPEND: begin
          app_r <= app_r + 1'b1;
          if (app_r == APP_END) begin
            upper_r      <= 1'b1;
            cur_none_r   <= 1'b1;
            best_found_r <= 1'b0;
            row_cnt_r    <= '0;
            iss_r        <= '0;
            hp_r         <= head_r;
            sum_r        <= '0;
            state_r      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (iss_r < n_r) begin
            rd_idx_r <= rd_addr;
            iss_r    <= iss_r + 1'b1;
          end
          if (take) begin
            best_found_r <= 1'b1;
            best_val_r   <= rd_data_r;
            best_idx_r   <= rd_idx_r;
          end
          if (rd_vld_r && (rd_idx_r == AW'(n_r - 1'b1))) state_r <= S_ROW;
        end
        S_ROW: begin
          if (out_free) begin
            out_from_track    <= hp_r;
            out_to_track      <= to_w;
            out_seek_distance <= dist_w;
            out_total_moved   <= sum_nxt;
            out_average_q8    <= '0;
            out_last_row      <= 1'b0;
            hp_r              <= to_w;
            sum_r             <= sum_nxt;
            row_cnt_r         <= row_cnt_r + 1'b1;
            best_found_r      <= 1'b0;
            iss_r             <= '0;
            if (best_found_r) begin
              cur_none_r <= 1'b0;
              cur_val_r  <= best_val_r;
              cur_idx_r  <= best_idx_r;
            end else begin
              // upper half exhausted: jump taken, sweep the lower half from the bottom
              upper_r    <= 1'b0;
              cur_none_r <= 1'b1;
            end
            if (row_last) begin
              out_valid_r <= 1'b0;
              state_r     <= S_DIV;
            end else begin
              out_valid_r <= 1'b1;
              state_r     <= S_SCAN;
            end
          end
        end
        S_DIV: begin
          // hold the final row until the average is ready
          if (div_res.done) begin
            out_average_q8 <= (div_res.quot > DVD_W'(AVG_MAX)) ? AVG_MAX
                                                               : div_res.quot[AVG_W-1:0];
            out_last_row   <= 1'b1;
            out_valid_r    <= 1'b1;
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

  `CSCAN_CHECK(a_cnt_bound, 1'b1, cnt_r <= CW'(MAX_REQUESTS), "request count beyond capacity")
  `CSCAN_CHECK(a_jump_upper, (state_r == S_ROW) && !best_found_r, upper_r, "empty lower pass")
  `CSCAN_CHECK(a_row_bound, (state_r == S_SCAN) || (state_r == S_ROW), row_cnt_r <= n_r, "row overrun")
  `CSCAN_CHECK_NEXT(a_div_start, div_start, state_r == S_DIV, "divider started outside final row")

endmodule
